>>> design/assert_macros.svh
// Assertion helper macros for the RTL.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is asserted.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> design/i2p_pkg.sv
// Types, character codes and helpers for the infix to postfix converter.
// No dependencies.
package i2p_pkg;

  localparam logic [7:0] CH_POW   = 8'h5E; // '^'
  localparam logic [7:0] CH_MUL   = 8'h2A; // '*'
  localparam logic [7:0] CH_DIV   = 8'h2F; // '/'
  localparam logic [7:0] CH_ADD   = 8'h2B; // '+'
  localparam logic [7:0] CH_SUB   = 8'h2D; // '-'
  localparam logic [7:0] CH_LPAR  = 8'h28; // '('
  localparam logic [7:0] CH_RPAR  = 8'h29; // ')'
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UZ    = 8'h5A;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LZ    = 8'h7A;

  typedef struct packed {
    logic [7:0] symbol;
    logic       last_symbol;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_symbol;
    logic       symbol_valid;
    logic       end_of_output;
    logic       stack_overflow;
  } out_item_t;

  typedef struct packed {
    logic       push;
    logic       pop;
    logic [7:0] data;
  } stack_cmd_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CHAR,
    S_FLUSH,
    S_DONE
  } conv_state_t;

  function automatic logic [1:0] prec_of(input logic [7:0] c);
    logic [1:0] p;
    if (c == CH_POW) p = 2'd3;
    else if (c == CH_MUL || c == CH_DIV) p = 2'd2;
    else if (c == CH_ADD || c == CH_SUB) p = 2'd1;
    else p = 2'd0;
    return p;
  endfunction

  function automatic logic is_operand(input logic [7:0] c);
    return (c >= CH_0 && c <= CH_9) || (c >= CH_UA && c <= CH_UZ) ||
           (c >= CH_LA && c <= CH_LZ);
  endfunction

endpackage

>>> design/i2p_stack.sv
// Operator stack: synchronous memory, entry count and registered top of stack.
// Depends on i2p_pkg (stack_cmd_t).
module i2p_stack import i2p_pkg::*; #(
  parameter int DEPTH = 32
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  stack_cmd_t                 cmd,
  output logic [$clog2(DEPTH+1)-1:0] count,
  output logic [7:0]                 top
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [7:0]    mem [DEPTH];
  logic [CW-1:0] cnt_r;
  logic [CW-1:0] cnt_nxt;
  logic [7:0]    top_r;
  logic [AW-1:0] wr_addr;
  logic [AW-1:0] rd_addr;
  logic [CW-1:0] rd_full;

  always_comb begin
    cnt_nxt = cnt_r;
    if (cmd.push) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (cmd.pop) begin
      cnt_nxt = cnt_r - CW'(1);
    end
    wr_addr = cnt_r[AW-1:0];
    rd_full = cnt_nxt - CW'(1);
    rd_addr = rd_full[AW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      mem[wr_addr] <= cmd.data;
    end
  end

  // Top tracks the entry below the next count; forward a same-cycle push.
  always_ff @(posedge clk) begin
    if (cmd.push && wr_addr == rd_addr) begin
      top_r <= cmd.data;
    end else begin
      top_r <= mem[rd_addr];
    end
  end

  assign count = cnt_r;
  assign top   = top_r;

endmodule

>>> design/infix_to_postfix_converter_top.sv
// Infix to postfix converter (shunting-yard) with an operator stack in memory.
// Sequence: an item passes S_IDLE, S_CHAR and S_DONE, staying in S_CHAR while it pops stack entries;
// the last item of an expression also passes S_FLUSH, which pops the rest and ends on seeing the empty
// stack. The stack memory gives one entry per cycle while the output is not stalled; output stalls hold
// the pops. Items are taken one at a time; a new character is accepted only in S_IDLE.
// Reset (rst_n, synchronous, active low) empties the stack and the output register;
// stack memory contents are not cleared.
`include "assert_macros.svh"
module infix_to_postfix_converter_top import i2p_pkg::*; #(
  parameter int STACK_DEPTH = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  localparam int CW = $clog2(STACK_DEPTH + 1);

  conv_state_t   state_r, state_nxt, after_char;
  logic [7:0]    c_r;
  logic          last_r;
  logic          drop_r;
  logic          hold_v_r, hold_v_nxt;
  logic [7:0]    hold_sym_r, hold_sym_nxt;
  logic          out_valid_r, out_valid_nxt;
  out_item_t     out_data_r, out_data_nxt;
  logic          out_load;
  logic          out_free;
  logic          can_gen;
  logic          gen;
  logic [7:0]    gen_sym;
  logic          accept;
  logic          drop_now;
  stack_cmd_t    stk_cmd;
  logic [CW-1:0] stk_cnt;
  logic [7:0]    stk_top;

  i2p_stack #(.DEPTH(STACK_DEPTH)) u_stack (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (stk_cmd),
    .count (stk_cnt),
    .top   (stk_top)
  );

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;
  assign can_gen  = !hold_v_r || out_free;
  assign after_char = last_r ? S_FLUSH : S_DONE;

  // A push is dropped only when the stack is full and nothing gets popped first.
  assign drop_now = !is_operand(in_data.symbol) && (in_data.symbol != CH_RPAR) &&
                    (stk_cnt == CW'(STACK_DEPTH)) &&
                    ((in_data.symbol == CH_LPAR) ||
                     (prec_of(stk_top) < prec_of(in_data.symbol)));

  always_comb begin
    state_nxt    = state_r;
    gen          = 1'b0;
    gen_sym      = stk_top;
    stk_cmd.push = 1'b0;
    stk_cmd.pop  = 1'b0;
    stk_cmd.data = c_r;
    out_load     = 1'b0;
    out_data_nxt = out_data_r;
    hold_v_nxt   = hold_v_r;
    hold_sym_nxt = hold_sym_r;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_CHAR;
        end
      end
      S_CHAR: begin
        if (is_operand(c_r)) begin
          if (can_gen) begin
            gen       = 1'b1;
            gen_sym   = c_r;
            state_nxt = after_char;
          end
        end else if (c_r == CH_LPAR) begin
          stk_cmd.push = !drop_r;
          state_nxt    = after_char;
        end else if (c_r == CH_RPAR) begin
          if (stk_cnt != '0 && stk_top != CH_LPAR) begin
            if (can_gen) begin
              gen         = 1'b1;
              stk_cmd.pop = 1'b1;
            end
          end else begin
            // discard the matching '(' if there is one
            stk_cmd.pop = (stk_cnt != '0);
            state_nxt   = after_char;
          end
        end else begin
          if (stk_cnt != '0 && prec_of(stk_top) >= prec_of(c_r)) begin
            if (can_gen) begin
              gen         = 1'b1;
              stk_cmd.pop = 1'b1;
            end
          end else begin
            stk_cmd.push = !drop_r;
            state_nxt    = after_char;
          end
        end
      end
      S_FLUSH: begin
        if (stk_cnt != '0) begin
          if (can_gen) begin
            gen         = 1'b1;
            stk_cmd.pop = 1'b1;
          end
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        // Held result goes out last so it can carry the end mark.
        if (hold_v_r || last_r || drop_r) begin
          if (out_free) begin
            out_load     = 1'b1;
            out_data_nxt = '{out_symbol:     hold_v_r ? hold_sym_r : 8'h00,
                             symbol_valid:   hold_v_r,
                             end_of_output:  last_r,
                             stack_overflow: drop_r};
            hold_v_nxt   = 1'b0;
            state_nxt    = S_IDLE;
          end
        end else begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (gen) begin
      if (hold_v_r) begin
        out_load     = 1'b1;
        out_data_nxt = '{out_symbol:     hold_sym_r,
                         symbol_valid:   1'b1,
                         end_of_output:  1'b0,
                         stack_overflow: drop_r};
      end
      hold_v_nxt   = 1'b1;
      hold_sym_nxt = gen_sym;
    end

    out_valid_nxt = out_load ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      hold_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      hold_v_r    <= hold_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hold_sym_r <= hold_sym_nxt;
    out_data_r <= out_data_nxt;
    if (accept) begin
      c_r    <= in_data.symbol;
      last_r <= in_data.last_symbol;
      drop_r <= drop_now;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `ASSERT_CLK(a_cnt_bound, clk, rst_n, stk_cnt <= CW'(STACK_DEPTH), "stack count above depth")
  `ASSERT_CLK(a_marker_zero, clk, rst_n, (out_valid && !out_data.symbol_valid) |-> (out_data.out_symbol == 8'h00), "marker carries a symbol")
  `ASSERT_CLK(a_idle_no_hold, clk, rst_n, (state_r == S_IDLE) |-> !hold_v_r, "held result left behind")
  `ASSERT_CLK(a_push_not_full, clk, rst_n, stk_cmd.push |-> (stk_cnt != CW'(STACK_DEPTH)), "push onto full stack")

endmodule
